// File: src/pfx_pkg.sv
`default_nettype none

package pfx_pkg;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADCHAR = 3'd1;
  localparam logic [2:0] ST_UNDER   = 3'd2;
  localparam logic [2:0] ST_OVER    = 3'd3;
  localparam logic [2:0] ST_DIVZERO = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // commands from controller to datapath
  typedef struct packed {
    logic       push;       // push digit of current character
    logic       set_err;    // record error code
    logic [2:0] err_code;
    logic       rd_issue;   // read entry below top of stack
    logic       alu_wr;     // write a+b or a-b to top, pop
    logic       sub;
    logic       mul_start;  // register full product
    logic       mul_fin;    // scale product, write top, pop
    logic       div_start;  // load divider
    logic       div_step;   // one quotient bit
    logic       div_fin;    // sign and saturate quotient, write top, pop
    logic       emit;       // load output word, clear stack and error
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;      // stack holds STACK_DEPTH entries
    logic lt2;       // fewer than two entries
    logic err_any;   // sticky error present
    logic b_zero;    // top of stack is zero
    logic div_last;  // current divider step is the last one
    logic out_busy;  // output word held and not taken this cycle
  } sts_t;

endpackage

`default_nettype wire

// File: src/pfx_ram.sv
`default_nettype none

module pfx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/pfx_ctrl.sv
`default_nettype none

module pfx_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         in_last,
  input  wire logic [7:0]   character,
  output logic              in_ready,
  output pfx_pkg::cmd_t     cmd,
  input  wire pfx_pkg::sts_t sts
);

  import pfx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_DIV,
    S_DIVEND,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  state_t state, state_next;
  op_t    op, op_next;
  logic   last, last_next;
  logic   is_digit, is_op, is_skip;
  op_t    dec_op;
  state_t done_state;

  // character decode
  always_comb begin
    is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
    is_skip  = (character == CH_SPACE) || (character == CH_NUL);
    is_op    = 1'b1;
    dec_op   = OP_ADD;
    case (character)
      CH_PLUS:  dec_op = OP_ADD;
      CH_MINUS: dec_op = OP_SUB;
      CH_STAR:  dec_op = OP_MUL;
      CH_SLASH: dec_op = OP_DIV;
      default:  is_op = 1'b0;
    endcase
  end

  assign in_ready   = (state == S_IDLE);
  assign done_state = last ? S_EMIT : S_IDLE;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    op_next    = op;
    last_next  = last;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          last_next  = in_last;
          state_next = in_last ? S_EMIT : S_IDLE;
          if (sts.err_any || is_skip) begin
            cmd = '0;
          end else if (is_digit) begin
            if (sts.full) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_OVER;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (is_op) begin
            if (sts.lt2) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_UNDER;
            end else begin
              cmd.rd_issue = 1'b1;
              op_next      = dec_op;
              state_next   = S_FETCH;
            end
          end else begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_BADCHAR;
          end
        end
      end
      S_FETCH: begin
        case (op)
          OP_ADD, OP_SUB: begin
            cmd.alu_wr = 1'b1;
            cmd.sub    = (op == OP_SUB);
            state_next = done_state;
          end
          OP_MUL: begin
            cmd.mul_start = 1'b1;
            state_next    = S_MUL;
          end
          OP_DIV: begin
            if (sts.b_zero) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_DIVZERO;
              state_next   = done_state;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
          default: state_next = done_state;
        endcase
      end
      S_MUL: begin
        cmd.mul_fin = 1'b1;
        state_next  = done_state;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DIVEND;
        end
      end
      S_DIVEND: begin
        cmd.div_fin = 1'b1;
        state_next  = done_state;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_ADD;
      last  <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      last  <= last_next;
    end
  end

endmodule

`default_nettype wire

// File: src/pfx_dpath.sv
`default_nettype none

module pfx_dpath #(
  parameter int STACK_DEPTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    character,
  input  wire pfx_pkg::cmd_t cmd,
  output pfx_pkg::sts_t      sts,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic [31:0]        out_value,
  output logic [2:0]         out_status
);

  import pfx_pkg::*;

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int NW   = 32 + FRAC_BITS;
  localparam int DCW  = $clog2(NW);
  localparam logic signed [63:0] MAXV = 64'sd2147483647;
  localparam logic signed [63:0] MINV = -64'sd2147483648;

  function automatic logic [31:0] sat64(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > MAXV) begin
      r = 32'h7FFF_FFFF;
    end else if (v < MINV) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic [CW-1:0]      count;
  logic [2:0]         err;
  logic [31:0]        tos;
  logic [31:0]        rd_data;
  logic signed [63:0] prod;
  logic [NW-1:0]      dnum;
  logic [32:0]        drem;
  logic [31:0]        dmag;
  logic               dneg;
  logic [DCW-1:0]     dcnt;

  logic signed [31:0] a_s, b_s;
  logic [3:0]         digit;
  logic signed [63:0] dig_ext, alu_sum, mul_sh;
  logic [31:0]        amag, bmag;
  logic [32:0]        rsh;
  logic               rfit;
  logic [63:0]        qx;
  logic [31:0]        div_res;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [CW-1:0]      cnt_m1, cnt_m2;

  assign cnt_m1 = count - CW'(1);
  assign cnt_m2 = count - CW'(2);
  assign waddr  = cnt_m1[AW-1:0];
  assign raddr  = cnt_m2[AW-1:0];
  assign we     = cmd.push && (count != '0);

  // entries below the top of stack; the top lives in tos
  pfx_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (tos),
    .re    (cmd.rd_issue),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // operand arithmetic
  always_comb begin
    a_s     = rd_data;
    b_s     = tos;
    digit   = 4'(character - CH_ZERO);
    dig_ext = 64'(digit) <<< FRAC_BITS;
    alu_sum = cmd.sub ? (64'(a_s) - 64'(b_s)) : (64'(a_s) + 64'(b_s));
    mul_sh  = prod >>> FRAC_BITS;
    amag    = a_s[31] ? (32'd0 - rd_data) : rd_data;
    bmag    = b_s[31] ? (32'd0 - tos) : tos;
  end

  // restoring divider step
  always_comb begin
    rsh  = {drem[31:0], dnum[NW-1]};
    rfit = (rsh >= {1'b0, dmag});
  end

  // quotient sign and saturation
  always_comb begin
    qx = 64'(dnum);
    if (!dneg) begin
      div_res = (qx[63:31] != '0) ? 32'h7FFF_FFFF : qx[31:0];
    end else if ((qx[63:32] != '0) || (qx[31] && (qx[30:0] != '0))) begin
      div_res = 32'h8000_0000;
    end else begin
      div_res = 32'd0 - qx[31:0];
    end
  end

  // stack count, error and top of stack
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err   <= ST_OK;
    end else begin
      if (cmd.emit) begin
        count <= '0;
        err   <= ST_OK;
      end else begin
        if (cmd.set_err) begin
          err <= cmd.err_code;
        end
        if (cmd.push) begin
          count <= count + CW'(1);
        end else if (cmd.alu_wr || cmd.mul_fin || cmd.div_fin) begin
          count <= cnt_m1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      tos <= sat64(dig_ext);
    end else if (cmd.alu_wr) begin
      tos <= sat64(alu_sum);
    end else if (cmd.mul_fin) begin
      tos <= sat64(mul_sh);
    end else if (cmd.div_fin) begin
      tos <= div_res;
    end
  end

  // multiplier and divider registers
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      prod <= a_s * b_s;
    end
    if (cmd.div_start) begin
      dnum <= NW'(amag) << FRAC_BITS;
      drem <= '0;
      dmag <= bmag;
      dneg <= a_s[31] ^ b_s[31];
      dcnt <= DCW'(NW - 1);
    end else if (cmd.div_step) begin
      drem <= rfit ? (rsh - {1'b0, dmag}) : rsh;
      dnum <= {dnum[NW-2:0], rfit};
      dcnt <= dcnt - DCW'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (err != ST_OK) begin
        out_status <= err;
        out_value  <= '0;
      end else if (count == '0) begin
        out_status <= ST_EMPTY;
        out_value  <= '0;
      end else begin
        out_status <= ST_OK;
        out_value  <= tos;
      end
    end
  end

  // status to controller
  always_comb begin
    sts.full     = (count == CW'(STACK_DEPTH));
    sts.lt2      = (count < CW'(2));
    sts.err_any  = (err != ST_OK);
    sts.b_zero   = (tos == '0);
    sts.div_last = (dcnt == '0);
    sts.out_busy = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

// File: src/postfix_expression_evaluator.sv
// channel  | dir | signals                          | contents
// s_axis   | in  | tvalid tready tdata[7:0] tlast   | character, is_last
// m_axis   | out | tvalid tready tdata[39:0]        | result_value, status
//
// digit, space, nul, bad character and any character after an error: handled in S_IDLE as taken
// + and -: S_FETCH, *: S_FETCH then S_MUL, all through the single stack read port
// /: S_FETCH, S_DIV with one quotient bit per cycle in the divider, then S_DIVEND
// a last character then passes through S_EMIT to load the output word, waiting while the old word is held
// rst is synchronous; it empties the stack, clears the error and drops the output valid
// a held output word only stalls the completion of the next last character
`default_nettype none

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] character
  input  wire logic        s_axis_tlast,   // is_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // [31:0] result_value, [34:32] status, [39:35] zero
);

  import pfx_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] out_value;
  logic [2:0]  out_status;

  // sequencer
  pfx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .character (s_axis_tdata),
    .in_ready  (s_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // stack, arithmetic and output word
  pfx_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .character  (s_axis_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_value  (out_value),
    .out_status (out_status)
  );

  assign m_axis_tdata = {5'd0, out_status, out_value};

endmodule

`default_nettype wire

// File: src/pfx_checker.sv
`default_nettype none

module pfx_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  import pfx_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // only defined status codes appear
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[34:32] == ST_OK) || (m_axis_tdata[34:32] == ST_BADCHAR) ||
                      (m_axis_tdata[34:32] == ST_UNDER) || (m_axis_tdata[34:32] == ST_OVER) ||
                      (m_axis_tdata[34:32] == ST_DIVZERO) || (m_axis_tdata[34:32] == ST_EMPTY))
    else $error("undefined status code");

  // an error or empty status carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[34:32] != ST_OK) |-> m_axis_tdata[31:0] == 32'd0)
    else $error("nonzero value with error status");

  // a new word appears only after a last character was taken
  a_new_word: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("output word loaded while input side idle");

  // nothing is shown right after reset
  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind postfix_expression_evaluator pfx_checker u_pfx_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
